// ----- rtl/bre_pkg.sv -----
// Shared types and constants of the bitmap range engine.
// Depends on nothing; every other file but bre_ram imports it.
package bre_pkg;

   // Widths fixed by the request and response fields.
   localparam int FIELD_W = 13;
   localparam int TYPE_W  = 3;

   typedef logic [TYPE_W-1:0]  req_code_type;
   typedef logic [FIELD_W-1:0] field_type;

   // Request codes; the two remaining codes are treated as no operation.
   localparam req_code_type REQ_TEST      = 3'd0;
   localparam req_code_type REQ_SET_BIT   = 3'd1;
   localparam req_code_type REQ_CLR_BIT   = 3'd2;
   localparam req_code_type REQ_SET_RANGE = 3'd3;
   localparam req_code_type REQ_CLR_RANGE = 3'd4;
   localparam req_code_type REQ_COUNT     = 3'd5;

   localparam field_type BITS_RESET = 13'd4096;
   localparam field_type COUNT_MAX  = 13'h1FFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_REM,
      ST_READ,
      ST_WALK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic load_en;
      logic div_en;
      logic rem_en;
      logic read_en;
      logic walk_en;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic skip;
      logic last_word;
   } status_type;

endpackage

// ----- rtl/bre_ram.sv -----
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on nothing.
module bre_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bre_ctrl.sv -----
// Sequencing state machine of the bitmap range engine.
// Depends on bre_pkg for the state, command and status types.
module bre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output bre_pkg::cmd_type    cmd,
   input  bre_pkg::status_type status
);

   import bre_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            state_in = ST_REM;
         end
         ST_REM: begin
            state_in = status.skip ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (status.last_word) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = start ? ST_DIV : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.load_en = start;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
         end
         ST_REM: begin
            cmd.rem_en = 1'b1;
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
         end
         ST_WALK: begin
            cmd.walk_en = 1'b1;
         end
         ST_DONE: begin
            busy        = 1'b0;
            rsp_strobe  = 1'b1;
            cmd.load_en = start;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/bre_dp.sv -----
// Datapath of the bitmap range engine: request registers, word and offset
// split, range masks, popcount, the map RAM and the size register.
// Depends on bre_pkg and bre_ram.
module bre_dp #(
   parameter int MAP_BITS  = 4096,
   parameter int WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bre_pkg::cmd_type      cmd,
   output bre_pkg::status_type   status,
   input  bre_pkg::req_code_type req_type,
   input  bre_pkg::field_type    req_begin_bit,
   input  bre_pkg::field_type    req_end_bit,
   input  logic                  csr_wr_en,
   input  bre_pkg::field_type    csr_wr_data,
   output logic                  rsp_old_bit,
   output bre_pkg::field_type    rsp_set_count,
   output logic                  rsp_range_error
);

   import bre_pkg::*;

   localparam int WORD_COUNT = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int OW         = $clog2(WORD_BITS);
   localparam int PW         = $clog2(WORD_BITS + 1);
   localparam int TW         = $clog2(MAP_BITS + 1);
   localparam int CW         = (TW > FIELD_W) ? TW : FIELD_W;
   localparam int LEVELS     = $clog2(WORD_BITS);
   // Reciprocal for the division by the word width; exact for 13-bit indexes.
   localparam int SH         = FIELD_W + OW + 1;
   localparam int RECIP      = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW         = $clog2(RECIP + 1);
   localparam int PRW        = FIELD_W + RW;

   req_code_type      type_ff;
   field_type         beg_ff;
   field_type         end_ff;
   field_type         e1_ff;
   field_type         bits_ff;
   field_type         qb_ff;
   field_type         qe_ff;
   logic [OW-1:0]     boff_ff;
   logic [OW-1:0]     eoff_ff;
   logic [AW-1:0]     cur_ff;
   logic [CW-1:0]     cnt_ff;
   logic              old_ff;
   logic              err_ff;
   logic              skip_ff;

   logic              is_single;
   logic              is_range;
   logic              req_single;
   logic              err_c;
   logic              skip_c;
   logic [CW-1:0]     size_c;
   logic [CW-1:0]     beg_w;
   logic [CW-1:0]     end_w;
   logic [PRW-1:0]    prod_b;
   logic [PRW-1:0]    prod_e;
   logic              at_first;
   logic              at_last;
   logic              modifies;
   logic              sets;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] sel_bits;
   logic [WORD_BITS-1:0] new_word;
   logic [PW-1:0]     pc_tree [WORD_BITS];
   logic [PW-1:0]     pc;
   logic              wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   assign req_single = (req_type == REQ_TEST) || (req_type == REQ_SET_BIT) ||
                       (req_type == REQ_CLR_BIT);
   assign is_single  = (type_ff == REQ_TEST) || (type_ff == REQ_SET_BIT) ||
                       (type_ff == REQ_CLR_BIT);
   assign is_range   = (type_ff == REQ_SET_RANGE) || (type_ff == REQ_CLR_RANGE) ||
                       (type_ff == REQ_COUNT);
   assign modifies   = (type_ff == REQ_SET_BIT) || (type_ff == REQ_CLR_BIT) ||
                       (type_ff == REQ_SET_RANGE) || (type_ff == REQ_CLR_RANGE);
   assign sets       = (type_ff == REQ_SET_BIT) || (type_ff == REQ_SET_RANGE);

   // Size in force is the register, limited to the map size.
   assign size_c = (CW'(bits_ff) > CW'(MAP_BITS)) ? CW'(MAP_BITS) : CW'(bits_ff);
   assign beg_w  = CW'(beg_ff);
   assign end_w  = CW'(end_ff);

   always_comb begin
      err_c = 1'b0;
      if (is_single) begin
         err_c = (beg_w >= size_c);
      end else if (is_range) begin
         err_c = (beg_w > end_w) || (end_w > size_c);
      end
   end

   assign skip_c = err_c || !(is_single || is_range) || (is_range && (beg_ff == end_ff));

   assign prod_b = PRW'(beg_ff) * PRW'(RECIP);
   assign prod_e = PRW'(e1_ff) * PRW'(RECIP);

   assign at_first = (cur_ff == AW'(qb_ff));
   assign at_last  = (cur_ff == AW'(qe_ff));

   // Bits of the current word that lie inside the range.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         mask[i] = (!at_first || (OW'(i) >= boff_ff)) && (!at_last || (OW'(i) <= eoff_ff));
      end
   end

   assign sel_bits = rd_data & mask;
   assign new_word = sets ? (rd_data | mask) : (rd_data & ~mask);

   // Popcount as a balanced adder tree.
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         pc_tree[i] = PW'(sel_bits[i]);
      end
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         for (int i = 0; i < WORD_BITS; i += (2 << lvl)) begin
            if (i + (1 << lvl) < WORD_BITS) begin
               pc_tree[i] = pc_tree[i] + pc_tree[i + (1 << lvl)];
            end
         end
      end
      pc = pc_tree[0];
   end

   assign wr_en   = cmd.clear_en || (cmd.walk_en && modifies);
   assign wr_data = cmd.clear_en ? '0 : new_word;
   assign rd_en   = cmd.read_en || (cmd.walk_en && !at_last);
   assign rd_addr = cmd.read_en ? cur_ff : cur_ff + AW'(1);

   bre_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control registers: word cursor (also the clearing counter) and size.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         bits_ff <= BITS_RESET;
      end else begin
         if (csr_wr_en) begin
            bits_ff <= csr_wr_data;
         end
         if (cmd.clear_en) begin
            cur_ff <= cur_ff + AW'(1);
         end else if (cmd.rem_en) begin
            cur_ff <= AW'(qb_ff);
         end else if (cmd.walk_en && !at_last) begin
            cur_ff <= cur_ff + AW'(1);
         end
      end
   end

   // Request and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         type_ff <= req_type;
         beg_ff  <= req_begin_bit;
         end_ff  <= req_end_bit;
         e1_ff   <= req_single ? req_begin_bit : req_end_bit - FIELD_W'(1);
         old_ff  <= 1'b0;
         cnt_ff  <= '0;
         err_ff  <= 1'b0;
      end
      if (cmd.div_en) begin
         qb_ff   <= FIELD_W'(prod_b >> SH);
         qe_ff   <= FIELD_W'(prod_e >> SH);
         err_ff  <= err_c;
         skip_ff <= skip_c;
      end
      if (cmd.rem_en) begin
         boff_ff <= OW'(beg_ff - FIELD_W'(qb_ff * WORD_BITS));
         eoff_ff <= OW'(e1_ff - FIELD_W'(qe_ff * WORD_BITS));
      end
      if (cmd.walk_en) begin
         if (type_ff == REQ_COUNT) begin
            cnt_ff <= cnt_ff + CW'(pc);
         end
         if (is_single) begin
            old_ff <= |sel_bits;
         end
      end
   end

   assign status.clear_last = (cur_ff == AW'(WORD_COUNT - 1));
   assign status.skip       = skip_ff;
   assign status.last_word  = at_last;

   assign rsp_old_bit     = old_ff;
   assign rsp_range_error = err_ff;
   assign rsp_set_count   = (cnt_ff > CW'(COUNT_MAX)) ? COUNT_MAX : FIELD_W'(cnt_ff);

endmodule

// ----- rtl/bitmap_range_engine.sv -----
// Top level of the bitmap range engine: joins the controller and datapath.
// Depends on bre_pkg, bre_ctrl, bre_dp (and through it bre_ram).
//
// The engine holds a map of MAP_BITS bits in a RAM of WORD_BITS-bit words
// (64 words of 64 bits by default) and serves one request at a time: test,
// set or clear one bit, set or clear a range, or count the ones in a range.
// A request beat is taken at a rising edge where start is high and busy is
// low. Each request gives exactly one response beat, shown for one cycle
// with rsp_strobe high; the receiver cannot stall it, so it must take the
// beat in that cycle. After reset the engine sweeps the RAM to zero, one word
// a cycle, and holds busy high until the sweep is done; csr writes are taken
// during the sweep as at any other time. A request then splits its indexes into
// word and bit offset in ST_DIV and ST_REM; the range walk primes the RAM read
// in ST_READ, then handles one map word a cycle in ST_WALK and writes it back
// for set and clear requests. The response follows in the next cycle, and a
// new request may be presented in that same cycle. An error, an empty range or
// an unknown code skips the read and the walk and goes from ST_REM straight to
// the response. The single RAM read and write port, one word per cycle, limits
// the speed of range requests. The size register csr_wr_data should be written
// only while the engine is idle.
module bitmap_range_engine #(
   parameter int MAP_BITS  = 4096,
   parameter int WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bre_pkg::req_code_type req_type,
   input  bre_pkg::field_type    req_begin_bit,
   input  bre_pkg::field_type    req_end_bit,
   input  logic                  csr_wr_en,
   input  bre_pkg::field_type    csr_wr_data,
   output logic                  rsp_strobe,
   output logic                  rsp_old_bit,
   output bre_pkg::field_type    rsp_set_count,
   output logic                  rsp_range_error
);

   import bre_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller only sequences; it sees the datapath through status.
   bre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds the map, the request and the result registers.
   bre_dp #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_type),
      .req_begin_bit   (req_begin_bit),
      .req_end_bit     (req_end_bit),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_old_bit     (rsp_old_bit),
      .rsp_set_count   (rsp_set_count),
      .rsp_range_error (rsp_range_error)
   );

endmodule

// ----- tb/bitmap_range_engine_tb.sv -----
// Self-checking testbench for the bitmap range engine: predicts every response beat
// from a shadow copy of the bit map and checks each one as it leaves the engine.
// Depends on bre_pkg and bitmap_range_engine, and through it on the other rtl files.
module bitmap_range_engine_tb;
   import bre_pkg::*;

   localparam int MAP_BITS       = 4096;
   localparam int MAP_WORD_BITS  = 64;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int PHASES         = 9;

   // The two request codes that the package leaves unnamed; the engine must ignore both.
   localparam req_code_type REQ_UNUSED_6 = 3'd6;
   localparam req_code_type REQ_UNUSED_7 = 3'd7;

   typedef struct packed {
      req_code_type code;
      field_type    first;
      field_type    past;
   } request_beat_type;

   typedef struct packed {
      logic      old_bit;
      field_type set_count;
      logic      range_error;
   } reply_beat_type;

   // Every input of the engine has a known value from time zero onwards.
   logic         clock         = 1'b0;
   logic         reset         = 1'b1;
   logic         start         = 1'b0;
   req_code_type req_type      = REQ_TEST;
   field_type    req_begin_bit = '0;
   field_type    req_end_bit   = '0;
   logic         csr_wr_en     = 1'b0;
   field_type    csr_wr_data   = '0;
   logic         busy;
   logic         rsp_strobe;
   logic         rsp_old_bit;
   field_type    rsp_set_count;
   logic         rsp_range_error;

   bitmap_range_engine #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (MAP_WORD_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_begin_bit   (req_begin_bit),
      .req_end_bit     (req_end_bit),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_old_bit     (rsp_old_bit),
      .rsp_set_count   (rsp_set_count),
      .rsp_range_error (rsp_range_error)
   );

   // Requests waiting to be driven, and the responses that the shadow map says must follow.
   request_beat_type pending_requests[$];
   reply_beat_type   predicted_replies[$];

   // Shadow of the engine's state: the whole map as one flat vector, and the size register.
   logic [MAP_BITS-1:0] shadow_map;
   field_type           size_shadow;

   logic        took_beat      = 1'b0;
   logic        sender_gaps_on = 1'b1;
   int unsigned gap_left       = 0;
   int unsigned beats_queued   = 0;
   int unsigned beats_taken    = 0;
   int unsigned replies_seen   = 0;
   int unsigned fail_count     = 0;
   int unsigned errors_seen    = 0;
   int unsigned counts_seen    = 0;
   int unsigned cycle_count    = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // Works out the response to one request and applies its effect to the shadow map.
   // The size in force is the register clipped to the map, so an oversized write acts
   // as the full map and a zero write turns away everything but an empty range at 0.
   function automatic reply_beat_type predict_reply(req_code_type code, field_type first,
                                                    field_type past);
      reply_beat_type reply;
      int unsigned    span;
      int unsigned    ones;
      reply = '0;
      ones  = 0;
      span  = (size_shadow > MAP_BITS) ? MAP_BITS : size_shadow;
      case (code)
         REQ_TEST, REQ_SET_BIT, REQ_CLR_BIT: begin
            if (first >= span) begin
               reply.range_error = 1'b1;
            end else begin
               reply.old_bit = shadow_map[first];
               if (code == REQ_SET_BIT) begin
                  shadow_map[first] = 1'b1;
               end else if (code == REQ_CLR_BIT) begin
                  shadow_map[first] = 1'b0;
               end
            end
         end
         REQ_SET_RANGE, REQ_CLR_RANGE, REQ_COUNT: begin
            // The end bit is exclusive, so a range with equal ends is valid and empty.
            if (first > past || past > span) begin
               reply.range_error = 1'b1;
            end else begin
               for (int n = first; n < past; n++) begin
                  if (code == REQ_COUNT) begin
                     ones += shadow_map[n];
                  end else begin
                     shadow_map[n] = (code == REQ_SET_RANGE);
                  end
               end
            end
            reply.set_count = (ones > COUNT_MAX) ? COUNT_MAX : field_type'(ones);
         end
         default: begin
            // Unknown codes leave the map alone and answer with all fields at zero.
         end
      endcase
      return reply;
   endfunction

   // Predictor: a request beat is taken at a rising edge where start is high and busy is
   // low. Inputs only change on the falling edge, and busy is read here before the
   // engine's own update of this edge lands, so the decision matches the engine's.
   always @(posedge clock) begin : request_predictor
      reply_beat_type reply;
      took_beat <= !reset && start && !busy;
      if (reset) begin
         shadow_map  = '0;
         size_shadow = BITS_RESET;
      end else begin
         if (csr_wr_en) begin
            size_shadow = csr_wr_data;
         end
         if (start && !busy) begin
            reply = predict_reply(req_type, req_begin_bit, req_end_bit);
            predicted_replies.push_back(reply);
            beats_taken++;
            if (reply.range_error) begin
               errors_seen++;
            end
            if (req_type == REQ_COUNT && !reply.range_error) begin
               counts_seen++;
            end
         end
      end
   end

   // Driver: holds a request on the bus until it is taken, then either presents the next
   // one at once or lowers start for a gap drawn when the request was presented. The
   // next value of start is worked out first so that start gets a single assignment.
   always @(negedge clock) begin : request_driver
      logic             next_start;
      request_beat_type beat;
      next_start = start;
      if (start && took_beat) begin
         next_start = 1'b0;
      end
      if (!next_start && !reset) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_requests.size() != 0) begin
            beat          = pending_requests.pop_front();
            req_type      <= beat.code;
            req_begin_bit <= beat.first;
            req_end_bit   <= beat.past;
            next_start    = 1'b1;
            gap_left      = sender_gaps_on ? $urandom_range(0, 12) : 0;
         end
      end
      start <= next_start;
   end

   // Monitor: a response beat lasts one cycle and cannot be held off, so it is checked
   // at the rising edge that ends the strobe cycle, against the oldest prediction.
   always @(posedge clock) begin : reply_monitor
      reply_beat_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         replies_seen++;
         if (predicted_replies.size() == 0) begin
            $error("response beat with no request outstanding");
            fail_count++;
         end else begin
            want = predicted_replies.pop_front();
            if (rsp_old_bit !== want.old_bit) begin
               $error("old_bit: expected %0d, got %0d", want.old_bit, rsp_old_bit);
               fail_count++;
            end
            if (rsp_set_count !== want.set_count) begin
               $error("set_count: expected %0d, got %0d", want.set_count, rsp_set_count);
               fail_count++;
            end
            if (rsp_range_error !== want.range_error) begin
               $error("range_error: expected %0d, got %0d", want.range_error,
                      rsp_range_error);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: stops a run that hangs and reports it as failed.
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d responses still awaited",
                  cycle_count, predicted_replies.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_request(req_code_type code, int unsigned first, int unsigned past);
      request_beat_type beat;
      beat.code  = code;
      beat.first = field_type'(first);
      beat.past  = field_type'(past);
      pending_requests.push_back(beat);
      beats_queued++;
   endtask

   // Returns once every queued request has been answered and the engine is idle again,
   // so that the size register can be changed safely.
   task automatic wait_until_drained();
      while (replies_seen != beats_queued || busy !== 1'b0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic write_size(int unsigned value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= field_type'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed requests inside the size in force, with short ranges favoured so
   // that the map stays patchy; the rest are boundary errors and raw noise over all
   // thirteen bits of each field and all eight codes.
   task automatic queue_random_requests(int unsigned count, int unsigned span);
      req_code_type code;
      int unsigned  pick;
      int unsigned  first;
      int unsigned  past;
      int unsigned  len;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         code = req_code_type'($urandom_range(REQ_TEST, REQ_COUNT));
         if (pick < 12) begin
            code  = req_code_type'($urandom_range(0, 7));
            first = $urandom_range(0, 8191);
            past  = $urandom_range(0, 8191);
         end else if (pick < 22) begin
            if ($urandom_range(0, 1) == 0) begin
               // Index at the size, or a range running one past it.
               first = span;
               past  = span + 1;
            end else begin
               // Range whose start lies beyond its end.
               past  = $urandom_range(0, span);
               first = past + $urandom_range(1, 3);
               code  = req_code_type'($urandom_range(REQ_SET_RANGE, REQ_COUNT));
            end
         end else if (span == 0) begin
            // With no bits in use only the empty range at zero is accepted.
            code  = req_code_type'($urandom_range(REQ_SET_RANGE, REQ_COUNT));
            first = 0;
            past  = 0;
         end else if (code <= REQ_CLR_BIT) begin
            case ($urandom_range(0, 7))
               0:       first = 0;
               1:       first = span - 1;
               default: first = $urandom_range(0, span - 1);
            endcase
            // The end field is ignored here, so it carries random content.
            past = $urandom_range(0, 8191);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               len = $urandom_range(0, (span < 130) ? span : 130);
            end else if (pick < 90) begin
               len = $urandom_range(0, span);
            end else begin
               len = span;
            end
            first = $urandom_range(0, span - len);
            past  = first + len;
         end
         queue_request(code, first, past);
      end
   endtask

   initial begin : stimulus
      int unsigned size_plan[PHASES];
      int unsigned count_plan[PHASES];
      int unsigned span;
      // The first phase runs on the reset value; the last size is drawn at random.
      size_plan  = '{MAP_BITS, 8191, 1, 0, 64, 65, 4095, MAP_BITS, 0};
      count_plan = '{200, 160, 80, 60, 160, 160, 200, 200, 230};
      size_plan[PHASES-1] = $urandom_range(2, MAP_BITS - 2);

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening on the full reset-sized map: the fresh map, both ends of the
      // map, indexes and ranges just past the end, begin beyond end, empty ranges, the
      // whole map at once, ranges across word boundaries and the two unused codes.
      queue_request(REQ_COUNT, 0, MAP_BITS);
      queue_request(REQ_SET_BIT, 0, 8191);
      queue_request(REQ_SET_BIT, MAP_BITS - 1, 0);
      queue_request(REQ_TEST, MAP_BITS - 1, 0);
      queue_request(REQ_CLR_BIT, 0, 0);
      queue_request(REQ_TEST, 0, 0);
      queue_request(REQ_TEST, MAP_BITS, 0);
      queue_request(REQ_SET_BIT, 8191, 0);
      queue_request(REQ_SET_RANGE, 0, MAP_BITS);
      queue_request(REQ_COUNT, 0, MAP_BITS);
      queue_request(REQ_CLR_RANGE, 1, MAP_BITS - 1);
      queue_request(REQ_COUNT, 0, MAP_BITS);
      queue_request(REQ_SET_RANGE, 60, 70);
      queue_request(REQ_COUNT, 59, 71);
      queue_request(REQ_CLR_RANGE, 10, 5);
      queue_request(REQ_COUNT, 0, MAP_BITS + 1);
      queue_request(REQ_SET_RANGE, 8191, 8191);
      queue_request(REQ_SET_RANGE, 100, 100);
      queue_request(REQ_COUNT, MAP_BITS, MAP_BITS);
      queue_request(REQ_UNUSED_6, 8191, 8191);
      queue_request(REQ_UNUSED_7, 0, 0);
      queue_request(REQ_CLR_RANGE, 0, MAP_BITS);
      queue_request(REQ_SET_BIT, 64, 0);
      queue_request(REQ_COUNT, 63, 65);
      queue_request(REQ_TEST, 63, 0);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            wait_until_drained();
            write_size(size_plan[p]);
            @(posedge clock);
         end
         // Every third phase runs the sender flat out, back to back.
         sender_gaps_on = (p % 3 != 1);
         span = (size_plan[p] > MAP_BITS) ? MAP_BITS : size_plan[p];
         queue_random_requests(count_plan[p], span);
      end

      wait_until_drained();
      repeat (8) @(posedge clock);

      $display("Ran %0d request beats over %0d size settings in %0d cycles;",
               beats_taken, PHASES, cycle_count);
      $display("%0d of them were range errors and %0d were valid counts.",
               errors_seen, counts_seen);
      if (fail_count == 0 && predicted_replies.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
